// ===== src/b64d_pkg.sv =====
// b64d_pkg: types, constants and the alphabet lookup for the base64/base64url decoder.
// No dependencies; used by b64d_core, b64d_fifo and base64url_stream_decoder.
package b64d_pkg;

   localparam int unsigned GROUP_MAX          = 3;  // most results one character causes
   localparam int unsigned RESULT_DEPTH_DFLT  = 8;  // result queue entries

   localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;  // '9'
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;  // '_'

   localparam logic [7:0] SEXTET_LOWER_BASE = 8'd26;
   localparam logic [7:0] SEXTET_DIGIT_BASE = 8'd52;
   localparam logic [5:0] SEXTET_62         = 6'd62;
   localparam logic [5:0] SEXTET_63         = 6'd63;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } b64d_sextet_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       last_out;
      logic       decode_error;
   } b64d_result_type;

   // results of one character, packed from slot 0 upward
   typedef struct packed {
      logic [1:0]                            count;
      b64d_result_type [GROUP_MAX-1:0]       res;
   } b64d_group_type;

   typedef struct packed {
      logic [1:0] quad_position;
      logic       error_seen;
   } b64d_status_type;

   function automatic b64d_sextet_type sextet_of(input logic [7:0] c);
      b64d_sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A + SEXTET_LOWER_BASE);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0 + SEXTET_DIGIT_BASE);
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         s.value = SEXTET_62;
      end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
         s.value = SEXTET_63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== src/b64d_core.sv =====
// b64d_core: quad state and byte formation for one accepted character.
// Depends on b64d_pkg for the alphabet lookup, result group and status types.
module b64d_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               char_in,
   input  logic                     last_in,
   output b64d_pkg::b64d_group_type  group_out,
   output b64d_pkg::b64d_status_type status_out
);

   logic [5:0] sextet_ff [3];
   logic [5:0] sextet_in [3];
   logic       third_pad_ff, third_pad_in;
   logic [1:0] quad_ff, quad_in;
   logic       err_ff, err_in;

   b64d_pkg::b64d_sextet_type sx;
   logic       is_pad, bad, err_now, emit, tp_eff, has_b1, has_b2;
   logic [5:0] s0, s1, s2;
   logic [7:0] b0, b1, b2;

   always_comb begin
      sx      = b64d_pkg::sextet_of(char_in);
      is_pad  = (char_in == b64d_pkg::CHAR_PAD);
      bad     = is_pad ? (quad_ff == b64d_pkg::POS_FIRST || quad_ff == b64d_pkg::POS_SECOND)
                       : !sx.valid;
      err_now = err_ff | bad;
      emit    = (quad_ff == b64d_pkg::POS_FOURTH) | last_in;

      // sextets as seen after this character is stored
      s0     = sextet_ff[0];
      s1     = (quad_ff == b64d_pkg::POS_SECOND) ? sx.value : sextet_ff[1];
      s2     = (quad_ff == b64d_pkg::POS_THIRD)  ? sx.value : sextet_ff[2];
      tp_eff = (quad_ff == b64d_pkg::POS_THIRD)  ? is_pad   : third_pad_ff;

      b0 = {s0, s1[5:4]};
      b1 = {s1[3:0], s2[5:2]};
      // pad then data: top bits come out set
      b2 = tp_eff ? {2'b11, sx.value} : {s2[1:0], sx.value};

      has_b1 = (quad_ff == b64d_pkg::POS_THIRD || quad_ff == b64d_pkg::POS_FOURTH) && !tp_eff;
      has_b2 = (quad_ff == b64d_pkg::POS_FOURTH) && !is_pad;
   end

   // next state
   always_comb begin
      sextet_in    = sextet_ff;
      third_pad_in = third_pad_ff;
      quad_in      = quad_ff;
      err_in       = err_ff;
      if (accept) begin
         case (quad_ff)
            b64d_pkg::POS_FIRST:  sextet_in[0] = sx.value;
            b64d_pkg::POS_SECOND: sextet_in[1] = sx.value;
            b64d_pkg::POS_THIRD: begin
               sextet_in[2] = sx.value;
               third_pad_in = is_pad;
            end
            default: ;
         endcase
         if (!emit) begin
            quad_in = quad_ff + 2'd1;
            err_in  = err_now;
         end else begin
            quad_in      = b64d_pkg::POS_FIRST;
            third_pad_in = 1'b0;
            err_in       = last_in ? 1'b0 : err_now;
         end
      end
   end

   // result group
   always_comb begin
      group_out = '0;
      if (accept && emit) begin
         if (quad_ff == b64d_pkg::POS_FIRST) begin
            // lone end: bare marker
            group_out.count               = 2'd1;
            group_out.res[0].last_out     = 1'b1;
            group_out.res[0].decode_error = 1'b1;
         end else begin
            group_out.res[0].byte_out   = b0;
            group_out.res[0].byte_valid = 1'b1;
            if (has_b1) begin
               group_out.res[1].byte_out   = b1;
               group_out.res[1].byte_valid = 1'b1;
               group_out.res[2].byte_out   = b2;
               group_out.res[2].byte_valid = 1'b1;
               group_out.count             = has_b2 ? 2'd3 : 2'd2;
            end else begin
               group_out.res[1].byte_out   = b2;
               group_out.res[1].byte_valid = 1'b1;
               group_out.count             = has_b2 ? 2'd2 : 2'd1;
            end
            for (int k = 0; k < b64d_pkg::GROUP_MAX; k++) begin
               group_out.res[k].decode_error = err_now;
               group_out.res[k].last_out     = last_in && (group_out.count == 2'(k + 1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sextet_ff[0] <= '0;
         sextet_ff[1] <= '0;
         sextet_ff[2] <= '0;
         third_pad_ff <= 1'b0;
         quad_ff      <= b64d_pkg::POS_FIRST;
         err_ff       <= 1'b0;
      end else begin
         sextet_ff    <= sextet_in;
         third_pad_ff <= third_pad_in;
         quad_ff      <= quad_in;
         err_ff       <= err_in;
      end
   end

   assign status_out.quad_position = quad_ff;
   assign status_out.error_seen    = err_ff;

endmodule

// ===== src/b64d_fifo.sv =====
// b64d_fifo: result queue; takes up to three results a cycle, hands out one.
// Depends on b64d_pkg for the result and group types.
module b64d_fifo #(
   parameter int unsigned Depth = b64d_pkg::RESULT_DEPTH_DFLT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  b64d_pkg::b64d_group_type  group_in,
   input  logic                      pop,
   output logic                      not_empty,
   output logic                      has_room,
   output b64d_pkg::b64d_result_type head,
   output logic [$clog2(Depth+1)-1:0] fill
);

   localparam int unsigned AW = $clog2(Depth);
   localparam int unsigned CW = $clog2(Depth + 1);

   b64d_pkg::b64d_result_type entry_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [1:0] k);
      logic [AW+1:0] sum;
      sum = (AW+2)'(p) + (AW+2)'(k);
      if (sum >= (AW+2)'(Depth)) begin
         sum = sum - (AW+2)'(Depth);
      end
      return sum[AW-1:0];
   endfunction

   always_comb begin
      wr_ptr_in = wrap_add(wr_ptr_ff, group_in.count);
      rd_ptr_in = pop ? wrap_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in  = count_ff + CW'(group_in.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < b64d_pkg::GROUP_MAX; k++) begin
         if (group_in.count > 2'(k)) begin
            entry_ff[wrap_add(wr_ptr_ff, 2'(k))] <= group_in.res[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   // room for a full group regardless of what drains this cycle
   assign has_room  = (count_ff <= CW'(Depth - b64d_pkg::GROUP_MAX));
   assign head      = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;

endmodule

// ===== src/base64url_stream_decoder.sv =====
// base64url_stream_decoder: base64 / base64url text to bytes, one character per transaction.
// Depends on b64d_pkg, b64d_core and b64d_fifo.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_char_in[7:0], req_last_in
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_byte_out[7:0], rsp_byte_valid,
//           |           |                       | rsp_last_out, rsp_decode_error
//
// One character is taken per cycle while req_ready is high; its zero to three results are
// decoded in the same cycle and written into a result queue of ResultDepth entries,
// drained one per cycle while rsp_ready is high. req_ready is high while the queue has
// room for three results, so with rsp_ready held high and the default ResultDepth the
// input never stalls (three bytes out per four characters in). Results are registered
// in the queue before rsp. Reset is synchronous and empties the queue and the quad state.
module base64url_stream_decoder #(
   parameter int unsigned ResultDepth = b64d_pkg::RESULT_DEPTH_DFLT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_byte_valid,
   output logic       rsp_last_out,
   output logic       rsp_decode_error
);

   localparam int unsigned CW = $clog2(ResultDepth + 1);

   logic                      accept, pop;
   b64d_pkg::b64d_group_type  group;
   b64d_pkg::b64d_status_type status;
   b64d_pkg::b64d_result_type head;
   logic [CW-1:0]             fill;

   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   b64d_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_in    (req_char_in),
      .last_in    (req_last_in),
      .group_out  (group),
      .status_out (status)
   );

   b64d_fifo #(.Depth(ResultDepth)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .group_in  (group),
      .pop       (pop),
      .not_empty (rsp_valid),
      .has_room  (req_ready),
      .head      (head),
      .fill      (fill)
   );

   assign rsp_byte_out     = head.byte_out;
   assign rsp_byte_valid   = head.byte_valid;
   assign rsp_last_out     = head.last_out;
   assign rsp_decode_error = head.decode_error;

   // queue never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= CW'(ResultDepth))
      else $error("result queue overfilled");

   // a final character always yields at least one result (checked as a fill that does not shrink)
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_in |=> fill >= $past(fill))
      else $error("final character produced no result");

   // the next string starts clean
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_in |=> status.quad_position == b64d_pkg::POS_FIRST
                                && !status.error_seen)
      else $error("quad state not cleared after final character");

   // a mid-quad character that is not final leaves no result
   a_mid_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !req_last_in && status.quad_position != b64d_pkg::POS_FOURTH
      |-> group.count == 2'd0)
      else $error("mid-quad character produced a result");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for base64url_stream_decoder, base64/base64url text to bytes.
// Depends on b64d_pkg and the decoder RTL; a built-in decoder model predicts each untyped result.
module tb;

   localparam int unsigned RANDOM_ITEMS = 320;
   localparam int unsigned HOLD_AT      = 60;     // characters after the directed part
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned PAUSE_AT     = 200;    // characters after the directed part
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int          PREDICTED    = -1;

   typedef enum int unsigned {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic [7:0]                            ch;
      logic                                  lst;
      int                                    n_typed;   // PREDICTED, or count of typed results
      b64d_pkg::b64d_result_type [2:0]       res;
   } char_row_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_byte_out;
   logic       rsp_byte_valid;
   logic       rsp_last_out;
   logic       rsp_decode_error;

   // decoder model state
   logic [5:0] sext_q [3] = '{6'd0, 6'd0, 6'd0};
   logic       pad3_q     = 1'b0;
   logic [1:0] pos_q      = b64d_pkg::POS_FIRST;
   logic       err_q      = 1'b0;

   char_row_type              char_rows [$];
   b64d_pkg::b64d_result_type pending_bytes [$];
   int unsigned     n_directed  = 0;
   int unsigned     n_accepted  = 0;
   int unsigned     n_checked   = 0;
   int unsigned     n_strings   = 0;
   int unsigned     n_flagged   = 0;
   int unsigned     n_fail      = 0;
   int unsigned     cycle_count = 0;

   base64url_stream_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_out     (rsp_last_out),
      .rsp_decode_error (rsp_decode_error)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic b64d_pkg::b64d_result_type mk_result(input logic [7:0] by,
                                                           input logic bv,
                                                           input logic lo, input logic er);
      b64d_pkg::b64d_result_type r;
      r.byte_out     = by;
      r.byte_valid   = bv;
      r.last_out     = lo;
      r.decode_error = er;
      return r;
   endfunction

   // Advance the decoder model by one character and return the results it causes.
   task automatic step_model(input logic [7:0] ch, input logic lst,
                             output int n, output b64d_pkg::b64d_result_type r [3]);
      logic [5:0] sx;
      logic       ok;
      logic       pad;
      logic       bad;
      logic [1:0] pos;
      logic [7:0] b [3];
      int         k;
      n   = 0;
      pos = pos_q;
      pad = (ch == b64d_pkg::CHAR_PAD);
      ok  = 1'b1;
      sx  = '0;
      if (ch >= b64d_pkg::CHAR_UPPER_A && ch <= b64d_pkg::CHAR_UPPER_Z) begin
         sx = 6'(ch - b64d_pkg::CHAR_UPPER_A);
      end else if (ch >= b64d_pkg::CHAR_LOWER_A && ch <= b64d_pkg::CHAR_LOWER_Z) begin
         sx = 6'(ch - b64d_pkg::CHAR_LOWER_A + b64d_pkg::SEXTET_LOWER_BASE);
      end else if (ch >= b64d_pkg::CHAR_DIGIT_0 && ch <= b64d_pkg::CHAR_DIGIT_9) begin
         sx = 6'(ch - b64d_pkg::CHAR_DIGIT_0 + b64d_pkg::SEXTET_DIGIT_BASE);
      end else if (ch == b64d_pkg::CHAR_PLUS || ch == b64d_pkg::CHAR_MINUS) begin
         sx = b64d_pkg::SEXTET_62;
      end else if (ch == b64d_pkg::CHAR_SLASH || ch == b64d_pkg::CHAR_UNDER) begin
         sx = b64d_pkg::SEXTET_63;
      end else begin
         ok = 1'b0;
      end
      bad = pad ? (pos < b64d_pkg::POS_THIRD) : !ok;
      if (bad) err_q = 1'b1;
      if (pos != b64d_pkg::POS_FOURTH) begin
         sext_q[pos] = sx;
         if (pos == b64d_pkg::POS_THIRD) pad3_q = pad;
      end
      if (pos != b64d_pkg::POS_FOURTH && !lst) begin
         pos_q = pos + 2'd1;
         return;
      end
      if (pos == b64d_pkg::POS_FIRST) begin
         err_q = 1'b1;
      end else begin
         b[n] = {sext_q[0], sext_q[1][5:4]};
         n++;
         if (pos != b64d_pkg::POS_SECOND && !pad3_q) begin
            b[n] = {sext_q[1][3:0], sext_q[2][5:2]};
            n++;
         end
         if (pos == b64d_pkg::POS_FOURTH && !pad) begin
            // data after '=' in the third slot keeps the two top bits set
            b[n] = pad3_q ? {2'b11, sx} : {sext_q[2][1:0], sx};
            n++;
         end
      end
      if (n == 0) begin
         r[0] = mk_result(8'h00, 1'b0, 1'b1, err_q);
         n = 1;
      end else begin
         for (k = 0; k < n; k++) begin
            r[k] = mk_result(b[k], 1'b1, lst && (k == n - 1), err_q);
         end
      end
      pos_q  = b64d_pkg::POS_FIRST;
      pad3_q = 1'b0;
      if (lst) err_q = 1'b0;
   endtask

   task automatic add_char(input logic [7:0] ch, input logic lst);
      char_row_type row;
      row         = '0;
      row.ch      = ch;
      row.lst     = lst;
      row.n_typed = PREDICTED;
      char_rows   = {char_rows, row};
   endtask

   task automatic add_typed(input logic [7:0] ch, input logic lst, input int n,
                            input b64d_pkg::b64d_result_type r0,
                            input b64d_pkg::b64d_result_type r1,
                            input b64d_pkg::b64d_result_type r2);
      char_row_type row;
      row         = '0;
      row.ch      = ch;
      row.lst     = lst;
      row.n_typed = n;
      row.res[0]  = r0;
      row.res[1]  = r1;
      row.res[2]  = r2;
      char_rows   = {char_rows, row};
   endtask

   function automatic logic [7:0] text_char(input int unsigned idx);
      if (idx < 26) return b64d_pkg::CHAR_UPPER_A + 8'(idx);
      if (idx < 52) return b64d_pkg::CHAR_LOWER_A + 8'(idx - 26);
      if (idx < 62) return b64d_pkg::CHAR_DIGIT_0 + 8'(idx - 52);
      if (idx == 62) return $urandom_range(0, 1) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_MINUS;
      return $urandom_range(0, 1) ? b64d_pkg::CHAR_SLASH : b64d_pkg::CHAR_UNDER;
   endfunction

   task automatic build_directed();
      b64d_pkg::b64d_result_type none, end_err, ones, zero;
      none    = '0;
      end_err = mk_result(8'h00, 1'b0, 1'b1, 1'b1);
      ones    = mk_result(8'hFF, 1'b1, 1'b0, 1'b0);
      zero    = mk_result(8'h00, 1'b1, 1'b0, 1'b0);
      // lone character at the end: bare end marker
      add_typed("A", 1'b1, 1, end_err, none, none);
      // all ones, quad completes without last
      add_char("/", 1'b0);
      add_char("/", 1'b0);
      add_char("/", 1'b0);
      add_typed("/", 1'b0, 3, ones, ones, ones);
      // all zeros, last on the fourth character
      add_char("A", 1'b0);
      add_char("A", 1'b0);
      add_char("A", 1'b0);
      add_typed("A", 1'b1, 3, zero, zero, mk_result(8'h00, 1'b1, 1'b1, 1'b0));
      // pad in the first slot
      add_char("=", 1'b0);
      add_typed("A", 1'b1, 1, mk_result(8'h00, 1'b1, 1'b1, 1'b1), none, none);
      // foreign character, then '_' for 63 and both alphabets for 62
      add_char(8'hFF, 1'b0);
      add_char("_", 1'b0);
      add_char("-", 1'b0);
      add_char("+", 1'b1);
      // pad in the third slot followed by data
      add_char("z", 1'b0);
      add_char("9", 1'b0);
      add_char("=", 1'b0);
      add_char("0", 1'b0);
      // short end with three characters
      add_char("a", 1'b0);
      add_char("b", 1'b0);
      add_char("c", 1'b1);
      // pad in the second slot as last character
      add_char("Q", 1'b0);
      add_char("=", 1'b1);
      add_typed(8'h00, 1'b1, 1, end_err, none, none);
   endtask

   task automatic add_clean_string();
      int unsigned nq, tail, total, len, k;
      bit          padded;
      nq   = $urandom_range(0, 3);
      tail = $urandom_range(0, 2);
      tail = (tail == 0) ? 0 : tail + 1;
      if (nq == 0 && tail == 0) tail = 2;
      total  = 4 * nq + tail;
      padded = (tail != 0) && ($urandom_range(0, 1) == 1);
      len    = padded ? 4 * nq + 4 : total;
      for (k = 0; k < len; k++) begin
         add_char((k < total) ? text_char($urandom_range(0, 63)) : b64d_pkg::CHAR_PAD,
                  k == len - 1);
      end
   endtask

   task automatic add_noise_string();
      int unsigned len, k, pick;
      logic [7:0]  ch;
      len = $urandom_range(1, 9);
      for (k = 0; k < len; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) ch = text_char($urandom_range(0, 63));
         else if (pick < 8) ch = b64d_pkg::CHAR_PAD;
         else ch = 8'($urandom_range(0, 255));
         add_char(ch, k == len - 1);
      end
   endtask

   // Predict on each accepted transaction, check each result transaction.
   always @(posedge clock) begin
      char_row_type              cur_row;
      int                        pred_n;
      b64d_pkg::b64d_result_type pred_res [3];
      b64d_pkg::b64d_result_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            cur_row = char_rows[n_accepted];
            n_accepted++;
            step_model(cur_row.ch, cur_row.lst, pred_n, pred_res);
            if (cur_row.n_typed == PREDICTED) begin
               for (int k = 0; k < pred_n; k++) pending_bytes = {pending_bytes, pred_res[k]};
            end else begin
               for (int k = 0; k < cur_row.n_typed; k++) begin
                  pending_bytes = {pending_bytes, cur_row.res[k]};
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (rsp_last_out) begin
               n_strings++;
               if (rsp_decode_error) n_flagged++;
            end
            if (pending_bytes.size() == 0) begin
               $error("rsp: result with nothing pending, byte_out 8'h%02h", rsp_byte_out);
               n_fail++;
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_byte_out !== want.byte_out) begin
                  $error("byte_out: expected 8'h%02h, got 8'h%02h", want.byte_out, rsp_byte_out);
                  n_fail++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, got %b", want.byte_valid, rsp_byte_valid);
                  n_fail++;
               end
               if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %b, got %b", want.last_out, rsp_last_out);
                  n_fail++;
               end
               if (rsp_decode_error !== want.decode_error) begin
                  $error("decode_error: expected %b, got %b", want.decode_error,
                         rsp_decode_error);
                  n_fail++;
               end
            end
         end
      end
   end

   // Receiver: stall pattern changes every stretch; one long hold-off fills the block.
   initial begin
      rx_mode_type mode;
      int unsigned span, k;
      bit          held;
      held = 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 160);
         for (k = 0; k < span; k++) begin
            if (!held && n_directed != 0 && n_accepted >= n_directed + HOLD_AT) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               RX_OPEN:     rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_ready <= (k % 4) != 3;
               default:     rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Sender: bursts of characters with random gaps; one pause until all results are out.
   initial begin
      int unsigned burst, gap, b, sent;
      bit          paused;
      build_directed();
      n_directed = char_rows.size();
      while (char_rows.size() < n_directed + RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) add_clean_string();
         else add_noise_string();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      sent   = 0;
      paused = 1'b0;
      while (sent < char_rows.size()) begin
         if (!paused && sent >= n_directed + PAUSE_AT) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_bytes.size() != 0) @(posedge clock);
         end
         burst = $urandom_range(1, 24);
         gap   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         for (b = 0; b < burst && sent < char_rows.size(); b++) begin
            req_valid   <= 1'b1;
            req_char_in <= char_rows[sent].ch;
            req_last_in <= char_rows[sent].lst;
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            sent++;
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d characters sent, %0d results checked", n_accepted, n_checked);
      $display("tb: %0d strings closed, %0d of them flagged as invalid", n_strings, n_flagged);
      if (n_fail == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $error("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_bytes.size());
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== base64url_stream_decoder.f =====
src/b64d_pkg.sv
src/b64d_core.sv
src/b64d_fifo.sv
src/base64url_stream_decoder.sv
bench/tb.sv
